// ===== rtl/bmve_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bmve_pkg;
    localparam int History = 8;
    localparam int Half = History / 2;
    localparam int Older = History - Half;
    localparam int HistW = $clog2(History);
    localparam int CordicIters = 14;
    localparam int IterW = $clog2(CordicIters + 1);
    localparam logic [15:0] ScaleReset = 16'd970;
    localparam logic [19:0] SpeedMax = 20'hFFFFF;
    localparam logic signed [17:0] AngPi = 18'sd32768;
    localparam logic signed [17:0] AngHalfPi = 18'sd16384;
    localparam logic [1:0] RegSpeedScale = 2'd0;

    typedef enum logic [2:0] {
        t_idle_st, t_sort_st, t_cordic_st, t_sqrt_st, t_mul_st, t_done_st
    } t_state;

    function automatic logic signed [17:0] atan_entry(input logic [IterW-1:0] i);
        case (i)
            4'd0: atan_entry = 18'sd8192;
            4'd1: atan_entry = 18'sd4836;
            4'd2: atan_entry = 18'sd2555;
            4'd3: atan_entry = 18'sd1297;
            4'd4: atan_entry = 18'sd651;
            4'd5: atan_entry = 18'sd326;
            4'd6: atan_entry = 18'sd163;
            4'd7: atan_entry = 18'sd81;
            4'd8: atan_entry = 18'sd41;
            4'd9: atan_entry = 18'sd20;
            4'd10: atan_entry = 18'sd10;
            4'd11: atan_entry = 18'sd5;
            4'd12: atan_entry = 18'sd3;
            4'd13: atan_entry = 18'sd1;
            default: atan_entry = 18'sd0;
        endcase
    endfunction
endpackage
`default_nettype wire

// ===== rtl/ball_median_velocity_estimator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Ball median velocity estimator. Each input beat is a new ball position; it is
// shifted into an 8-entry history per axis. The block finds the upper median of
// the newer and older halves (one candidate a cycle plus a capture), then runs
// a shared CORDIC shift-add unit for the heading (a load, then 14 steps), a
// 21-step restoring square root for the magnitude, one multiply by speed_scale
// and a move of the result into the output register. The input is stalled
// while the sequencer is busy, so a new beat is taken only once the last one
// has reached the output register. The result waits in the output register
// until taken, so the next beat runs in the meantime; only when the next
// result is ready before the old one is taken does the sequencer hold, and
// the input stays stalled.
// Heading is folded: 32768 = pi; zero motion gives -32768 and speed 0.
module ball_median_velocity_estimator_unit import bmve_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [9:0]  i_ball_x,
    input  wire logic [9:0]  i_ball_y,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic signed [15:0] o_heading,
    output logic [19:0]      o_speed,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    t_state r_state, n_state;
    logic [10*History-1:0] r_hx, r_hy;
    logic [15:0] r_scale;
    logic [4:0] r_cnt, n_cnt;
    logic signed [11:0] r_dx, r_dy;
    logic signed [21:0] r_x, r_y;
    logic signed [17:0] r_z;
    logic [20:0] r_root;
    logic [36:0] r_prod;
    logic r_out_valid;
    logic w_accept, w_out_take, w_load;
    logic [9:0] w_mxn, w_mxo, w_myn, w_myo;
    logic [HistW:0] c_base0, c_cntn, c_cnto;

    assign pready = 1'b1;
    assign prdata = (paddr == RegSpeedScale) ? {16'd0, r_scale} : 32'd0;
    assign w_accept = i_valid && !o_stall;
    assign w_out_take = o_valid && !i_stall;
    // result moves to the output register once that register is free
    assign w_load = (r_state == t_done_st) && (!r_out_valid || w_out_take);
    assign c_base0 = '0;
    assign c_cntn = (HistW+1)'(Half);
    assign c_cnto = (HistW+1)'(Older);

    // four medians share a comparator bank each; candidate index is the counter
    bmve_median u_mxn (.i_clk, .i_start(w_accept), .i_hist(r_hx), .i_base(c_base0),
        .i_cnt(c_cntn), .i_cand(r_cnt[HistW-1:0]), .o_med(w_mxn));
    bmve_median u_mxo (.i_clk, .i_start(w_accept), .i_hist(r_hx), .i_base(c_cntn),
        .i_cnt(c_cnto), .i_cand(r_cnt[HistW-1:0]), .o_med(w_mxo));
    bmve_median u_myn (.i_clk, .i_start(w_accept), .i_hist(r_hy), .i_base(c_base0),
        .i_cnt(c_cntn), .i_cand(r_cnt[HistW-1:0]), .o_med(w_myn));
    bmve_median u_myo (.i_clk, .i_start(w_accept), .i_hist(r_hy), .i_base(c_cntn),
        .i_cnt(c_cnto), .i_cand(r_cnt[HistW-1:0]), .o_med(w_myo));

    logic signed [11:0] w_dx, w_dy;
    logic [10:0] w_ax, w_ay;
    assign w_dx = $signed({2'b0, w_mxn}) - $signed({2'b0, w_mxo});
    assign w_dy = $signed({2'b0, w_myn}) - $signed({2'b0, w_myo});
    assign w_ax = r_dx[11] ? 11'(-r_dx) : r_dx[10:0];
    assign w_ay = r_dy[11] ? 11'(-r_dy) : r_dy[10:0];

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt + 1'b1;
        case (r_state)
            t_idle_st: begin
                n_cnt = '0;
                if (w_accept) n_state = t_sort_st;
            end
            t_sort_st: if (r_cnt == 5'(Older)) begin
                n_state = t_cordic_st;
                n_cnt = '0;
            end
            t_cordic_st: if (r_cnt == 5'(CordicIters)) begin
                n_state = t_sqrt_st;
                n_cnt = '0;
            end
            t_sqrt_st: if (r_cnt == 5'd20) n_state = t_mul_st;
            t_mul_st: n_state = t_done_st;
            t_done_st: if (w_load) n_state = t_idle_st;
            default: n_state = t_idle_st;
        endcase
    end

    // outputs
    always_comb begin
        o_stall = (r_state != t_idle_st);
        o_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_idle_st;
            r_cnt <= '0;
            r_hx <= '0;
            r_hy <= '0;
            r_scale <= ScaleReset;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            if (psel && penable && pwrite && paddr == RegSpeedScale)
                r_scale <= pwdata[15:0];
            if (w_accept) begin
                r_hx <= {r_hx[10*(History-1)-1:0], i_ball_x};
                r_hy <= {r_hy[10*(History-1)-1:0], i_ball_y};
            end
            if (w_load) r_out_valid <= 1'b1;
            else if (w_out_take) r_out_valid <= 1'b0;
        end
    end

    // datapath: difference capture, cordic, scaling
    logic signed [21:0] w_xs, w_ys;
    logic [IterW-1:0] w_i;
    assign w_i = r_cnt[IterW-1:0] - 1'b1;
    assign w_xs = r_x >>> w_i;
    assign w_ys = r_y >>> w_i;

    always_ff @(posedge i_clk) begin
        case (r_state)
            t_sort_st: if (r_cnt == 5'(Older)) begin
                r_dx <= w_dx;
                r_dy <= w_dy;
            end
            t_cordic_st: begin
                if (r_cnt == '0) begin
                    r_x <= $signed({3'b0, w_ax, 8'b0});
                    r_y <= $signed({3'b0, w_ay, 8'b0});
                    r_z <= '0;
                end else if (r_y > 0) begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + atan_entry(w_i);
                end else begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - atan_entry(w_i);
                end
            end
            t_mul_st: r_prod <= {16'd0, r_root} * {21'd0, r_scale};
            default: ;
        endcase
    end

    // restoring square root kept as separate partial remainder
    // one result bit per step, top pair of the source first
    logic [22:0] r_sq_rem;
    logic [41:0] r_sq_src;
    logic [22:0] w_sq_try;
    assign w_sq_try = {r_sq_rem[20:0], r_sq_src[41:40]} - {r_root, 2'b01};
    always_ff @(posedge i_clk) begin
        if (r_state == t_cordic_st && r_cnt == '0) begin
            r_sq_rem <= '0;
            r_sq_src <= 42'(({11'd0, w_ax} * {11'd0, w_ax}) +
                        ({11'd0, w_ay} * {11'd0, w_ay})) << 16;
        end else if (r_state == t_sqrt_st) begin
            r_sq_src <= r_sq_src << 2;
            if (!w_sq_try[22]) begin
                r_sq_rem <= w_sq_try;
            end else begin
                r_sq_rem <= {r_sq_rem[20:0], r_sq_src[41:40]};
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (r_state == t_cordic_st && r_cnt == '0) begin
            r_root <= '0;
        end else if (r_state == t_sqrt_st) begin
            r_root <= {r_root[19:0], !w_sq_try[22]};
        end
    end

    // heading fold
    logic signed [17:0] w_z, w_a, w_f;
    always_comb begin
        w_z = r_z;
        if (w_ay == '0) w_z = '0;
        else if (w_ax == '0) w_z = AngHalfPi;
        else if (r_z < 0) w_z = '0;
        else if (r_z > AngHalfPi) w_z = AngHalfPi;
        if (!r_dx[11]) w_a = r_dy[11] ? -w_z : w_z;
        else w_a = r_dy[11] ? w_z - AngPi : AngPi - w_z;
        w_f = w_a;
        if (w_a < 0 && w_a >= -AngHalfPi) w_f = w_a + AngPi;
        else if (w_a >= 0 && w_a <= AngHalfPi) w_f = w_a - AngPi;
    end

    // output register, speed saturates when the scaled value passes 20 bits
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_heading <= w_f[15:0];
            o_speed <= r_prod[36] ? SpeedMax : r_prod[35:16];
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_heading) && $stable(o_speed)))
        else $error("result dropped or changed while stalled");
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == t_idle_st) |-> !o_stall) else $error("idle but stalling");
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == t_sort_st)) else $error("sequencer missed beat");
endmodule
`default_nettype wire

// ===== rtl/bmve_median.sv =====
`timescale 1ns / 1ps
`default_nettype none
// median of a window by counting: one candidate per cycle through one comparator bank
module bmve_median import bmve_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_start,
    input  wire logic [10*History-1:0] i_hist,
    input  wire logic [HistW:0]    i_base,
    input  wire logic [HistW:0]    i_cnt,
    input  wire logic [HistW-1:0]  i_cand,
    output logic [9:0]             o_med
);
    logic [9:0] w_c;
    logic [HistW:0] w_lt, w_le, w_k;
    logic [HistW:0] w_ci;

    // upper middle = element v with count(<v) <= k < count(<=v), k = n/2
    always_comb begin
        w_ci = {1'b0, i_cand} + i_base;
        w_c = i_hist[10*w_ci[HistW-1:0] +: 10];
        w_lt = '0;
        w_le = '0;
        w_k = i_cnt >> 1;
        for (int j = 0; j < History; j++) begin
            if ((j >= i_base) && (j < i_base + i_cnt)) begin
                if (i_hist[10*j +: 10] < w_c) w_lt = w_lt + 1'b1;
                if (i_hist[10*j +: 10] <= w_c) w_le = w_le + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            o_med <= '0;
        end else if ({1'b0, i_cand} < i_cnt && w_lt <= w_k && w_k < w_le) begin
            o_med <= w_c;
        end
    end
endmodule
`default_nettype wire
